FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled during reset
`define AST_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
// next-cycle implication, disabled during reset
`define AST_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

FILE: rtl/core/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// shared widths, geometry constants and register indexes
// ----------------------------------------------------------------------------
`default_nettype none
package pid_pkg;
  localparam int POS_W   = 12;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 3;
  localparam int FRAC_SH = 8;
  localparam int RSQ_W   = 24;
  localparam int SQN_W   = 40;
  localparam int ROOT_W  = 20;
  localparam int DW      = 26;
  localparam int SW      = 2 * DW;

  localparam int HOLE_ROUND_RADIUS   = 0;
  localparam int TOP_ROUND_RADIUS    = 0;
  localparam int BOTTOM_ROUND_RADIUS = 0;
  localparam int OUTER_TAPER_LEN     = 0;
  localparam int OUTER_TAPER_WID     = 0;
  localparam int BOTTOM_TAPER_LEN    = 0;

  // 0.8, 0.71 and 0.7 in units of 1/256
  localparam int K_HOLE   = 205;
  localparam int K_BTAPER = 182;
  localparam int K_BULLET = 179;

  localparam logic [IDX_W-1:0] REG_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RAD  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LITH = 3'd2;
  localparam logic [IDX_W-1:0] REG_PCL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PCR  = 3'd4;
  localparam logic [IDX_W-1:0] REG_PCRND = 3'd5;
  localparam logic [IDX_W-1:0] REG_HR   = 3'd6;
  localparam logic [IDX_W-1:0] REG_HL   = 3'd7;
endpackage
`default_nettype wire

FILE: rtl/core/pid_ifs.sv
// ----------------------------------------------------------------------------
// pid stream interfaces
// point beats in, classification beats out
// ----------------------------------------------------------------------------
`default_nettype none
interface pid_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pid_pkg::POS_W-1:0]   pos_x;
  logic signed [pid_pkg::POS_W-1:0]   pos_y;
  logic signed [pid_pkg::POS_W-1:0]   pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pid_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/point_in_detector_solid_test_core.sv
// ----------------------------------------------------------------------------
// point_in_detector_solid_test_core
// classifies a 3d point as inside or outside the active crystal volume
// ----------------------------------------------------------------------------
// depth: 25 stages plus the output register from input beat to output beat
// throughput: one beat per cycle unless the output stalls; the 20-stage square-root pipeline sets depth
// stalls back up stage by stage, bubbles are squeezed out
// reset: synchronous active-low rst_n clears valid bits and loads register
//   defaults
`default_nettype none
`include "assert_macros.svh"
module point_in_detector_solid_test_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pid_in_if.sink                             in_bus,
  pid_out_if.source                          out_bus,
  input  wire logic                          cfg_we,
  input  wire logic [pid_pkg::IDX_W-1:0]     cfg_idx,
  input  wire logic [pid_pkg::CFG_W-1:0]     cfg_data
);
  localparam int DW = pid_pkg::DW;
  localparam int SW = pid_pkg::SW;
  localparam int PW = pid_pkg::POS_W;
  localparam int NSQ = pid_pkg::ROOT_W;     // one root bit per stage
  localparam int SQ0 = 3;                   // first root stage index
  localparam int SD  = SQ0 + NSQ;           // operand stage
  localparam int SM  = SD + 1;              // squaring stage
  localparam int NS  = SM + 1;

  // configuration registers
  logic [10:0] len_r, rad_r, pcl_r, pcr_r, hr_r, hl_r;
  logic [7:0]  lith_r;
  logic        pcrnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 11'd1280;
      rad_r   <= 11'd560;
      lith_r  <= 8'd16;
      pcl_r   <= 11'd32;
      pcr_r   <= 11'd24;
      pcrnd_r <= 1'b0;
      hr_r    <= 11'd80;
      hl_r    <= 11'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pid_pkg::REG_LEN:   len_r   <= cfg_data;
        pid_pkg::REG_RAD:   rad_r   <= cfg_data;
        pid_pkg::REG_LITH:  lith_r  <= cfg_data[7:0];
        pid_pkg::REG_PCL:   pcl_r   <= cfg_data;
        pid_pkg::REG_PCR:   pcr_r   <= cfg_data;
        pid_pkg::REG_PCRND: pcrnd_r <= cfg_data[0];
        pid_pkg::REG_HR:    hr_r    <= cfg_data;
        pid_pkg::REG_HL:    hl_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared signed views of the geometry
  logic signed [DW-1:0] s_len, s_rad, s_lith, s_pcl, s_pcr, s_hr, s_hl;
  logic signed [DW-1:0] zmax_g, rmax_g;
  assign s_len  = DW'(len_r);
  assign s_rad  = DW'(rad_r);
  assign s_lith = DW'(lith_r);
  assign s_pcl  = DW'(pcl_r);
  assign s_pcr  = DW'(pcr_r);
  assign s_hr   = DW'(hr_r);
  assign s_hl   = DW'(hl_r);
  assign zmax_g = s_len - s_lith;
  assign rmax_g = s_rad - s_lith;

  // stage handshake: a stage moves when it is empty or its successor moves
  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic          out_v_r, out_res_r;

  always_comb begin
    en[NS] = !out_v_r || out_bus.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign in_bus.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_bus.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
      if (en[NS]) out_v_r <= v_r[NS-1];
    end
  end

  // z and the early reject flag ride along the whole front half
  logic signed [PW-1:0] z_r   [0:SD-1];
  logic                 bad_r [2:SD-1];

  // stage 0: input register
  logic signed [PW-1:0] x0_r, y0_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r   <= in_bus.pos_x;
      y0_r   <= in_bus.pos_y;
      z_r[0] <= in_bus.pos_z;
    end
  end

  // stage 1: squares of x and y, slab test
  logic [2*PW-1:0] xx1_r, yy1_r;
  logic            slab1_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      xx1_r   <= unsigned'((2*PW)'(x0_r) * (2*PW)'(x0_r));
      yy1_r   <= unsigned'((2*PW)'(y0_r) * (2*PW)'(y0_r));
      slab1_r <= (DW'(z_r[0]) >= zmax_g) || (z_r[0] < 0);
      z_r[1]  <= z_r[0];
    end
  end

  // stage 2: radius squared, cylinder wall test
  logic [pid_pkg::RSQ_W-1:0] rsq_w;
  logic signed [SW-1:0]      rmax_sq;
  assign rsq_w   = pid_pkg::RSQ_W'(xx1_r) + pid_pkg::RSQ_W'(yy1_r);
  assign rmax_sq = rmax_g * rmax_g;

  logic [pid_pkg::SQN_W-1:0] rem_r [SQ0-1:SD-1];
  logic [pid_pkg::SQN_W-1:0] res_r [SQ0-1:SD-1];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_r[2] <= {rsq_w, 16'd0};
      res_r[2] <= '0;
      bad_r[2] <= slab1_r || (signed'(SW'(rsq_w)) > rmax_sq);
      z_r[2]   <= z_r[1];
    end
  end

  // square-root stages, one result bit each
  for (genvar j = 0; j < NSQ; j++) begin : g_root
    localparam logic [pid_pkg::SQN_W-1:0] BIT =
      pid_pkg::SQN_W'(1) << (2 * (NSQ - 1 - j));
    logic [pid_pkg::SQN_W-1:0] trial;
    assign trial = res_r[SQ0-1+j] + BIT;
    always_ff @(posedge clk) begin
      if (en[SQ0+j]) begin
        if (rem_r[SQ0-1+j] >= trial) begin
          rem_r[SQ0+j] <= rem_r[SQ0-1+j] - trial;
          res_r[SQ0+j] <= (res_r[SQ0-1+j] >> 1) + BIT;
        end else begin
          rem_r[SQ0+j] <= rem_r[SQ0-1+j];
          res_r[SQ0+j] <= res_r[SQ0-1+j] >> 1;
        end
        bad_r[SQ0+j] <= bad_r[SQ0-1+j];
        z_r[SQ0+j]   <= z_r[SQ0-1+j];
      end
    end
  end

  // operand stage: region entry flags and difference terms
  logic signed [DW-1:0] r_w, zq_w, r1_w, z1_w, zmax_w;
  logic signed [DW-1:0] pca, hbr, hb, ha, hrl, bt_t, brt, brb, lq;
  assign r_w    = DW'(res_r[SD-1][pid_pkg::ROOT_W-1:0]);
  assign zq_w   = DW'(z_r[SD-1]) <<< pid_pkg::FRAC_SH;
  assign zmax_w = zmax_g <<< pid_pkg::FRAC_SH;
  assign r1_w   = (rmax_g <<< pid_pkg::FRAC_SH) - r_w;
  assign z1_w   = zmax_w - zq_w;
  assign lq     = s_lith <<< pid_pkg::FRAC_SH;
  assign pca    = (s_pcl > s_pcr) ? ((s_pcl - s_pcr) <<< pid_pkg::FRAC_SH)
                                  : ((s_pcr - s_pcl) <<< pid_pkg::FRAC_SH);
  assign hbr    = DW'(pid_pkg::HOLE_ROUND_RADIUS * 256) + s_lith * DW'(pid_pkg::K_HOLE);
  assign hb     = zmax_w - (s_hl <<< pid_pkg::FRAC_SH) + hbr;
  assign hrl    = (s_hr + s_lith) <<< pid_pkg::FRAC_SH;
  assign ha     = hrl - hbr;
  assign bt_t   = DW'(pid_pkg::BOTTOM_TAPER_LEN * 256) + s_lith * DW'(pid_pkg::K_BTAPER);
  assign brt    = DW'(pid_pkg::TOP_ROUND_RADIUS * 256) - s_lith * DW'(pid_pkg::K_BULLET);
  assign brb    = DW'(pid_pkg::BOTTOM_ROUND_RADIUS * 256) - s_lith * DW'(pid_pkg::K_BULLET);

  typedef struct packed {
    logic bad;
    logic pc_in;
    logic pc_short;
    logic bo_in;
    logic bo_short;
    logic ot_in;
    logic bt_out;
    logic tp_in;
    logic bm_in;
  } flags_t;

  flags_t               fd_r, fm_r;
  logic signed [DW-1:0] pc_u_r, pc_w_r, pc_l_r, bo_u_r, bo_w_r, bo_l_r;
  logic signed [DW-1:0] ot_u_r, ot_w_r, tp_u_r, tp_w_r, tp_l_r;
  logic signed [DW-1:0] bm_u_r, bm_w_r, bm_l_r;

  always_ff @(posedge clk) begin
    if (en[SD]) begin
      fd_r.bad      <= bad_r[SD-1];
      fd_r.pc_in    <= (s_len >= 0) && (DW'(z_r[SD-1]) <= s_pcl) &&
                       (r_w <= (s_pcr <<< pid_pkg::FRAC_SH));
      // flat contact counts as fully dead
      fd_r.pc_short <= !pcrnd_r || ((s_pcl > s_pcr) ? (zq_w <= pca) : (r_w <= pca));
      pc_u_r        <= (s_pcl > s_pcr) ? (zq_w - pca) : zq_w;
      pc_w_r        <= (s_pcl > s_pcr) ? r_w : (r_w - pca);
      pc_l_r        <= (s_pcl > s_pcr) ? (s_pcr <<< pid_pkg::FRAC_SH)
                                       : (s_pcl <<< pid_pkg::FRAC_SH);
      fd_r.bo_in    <= (r_w <= hrl) && (z1_w <= (s_hl <<< pid_pkg::FRAC_SH));
      fd_r.bo_short <= (zq_w >= hb) || (r_w <= ha);
      bo_u_r        <= hb - zq_w;
      bo_w_r        <= ha - r_w;
      bo_l_r        <= hbr;
      fd_r.ot_in    <= (pid_pkg::OUTER_TAPER_LEN > 0) &&
                       (z1_w <= DW'(pid_pkg::OUTER_TAPER_LEN * 256));
      ot_u_r        <= r1_w;
      ot_w_r        <= DW'(pid_pkg::OUTER_TAPER_LEN * 256) - z1_w;
      fd_r.bt_out   <= (zq_w <= bt_t) && (r1_w <= bt_t - zq_w);
      fd_r.tp_in    <= (z1_w <= brt) && (r1_w <= brt);
      tp_u_r        <= brt - r1_w;
      tp_w_r        <= brt - z1_w;
      tp_l_r        <= brt;
      fd_r.bm_in    <= (zq_w <= brb + lq) && (r1_w <= brb);
      bm_u_r        <= brb - r1_w;
      bm_w_r        <= brb - zq_w + lq;
      bm_l_r        <= brb;
    end
  end

  // squaring stage
  logic signed [SW-1:0] pc_u2_r, pc_w2_r, pc_l2_r, bo_u2_r, bo_w2_r, bo_l2_r;
  logic signed [SW-1:0] ot_p_r, ot_q_r, tp_u2_r, tp_w2_r, tp_l2_r;
  logic signed [SW-1:0] bm_u2_r, bm_w2_r, bm_l2_r;

  always_ff @(posedge clk) begin
    if (en[SM]) begin
      fm_r    <= fd_r;
      pc_u2_r <= SW'(pc_u_r) * SW'(pc_u_r);
      pc_w2_r <= SW'(pc_w_r) * SW'(pc_w_r);
      pc_l2_r <= SW'(pc_l_r) * SW'(pc_l_r);
      bo_u2_r <= SW'(bo_u_r) * SW'(bo_u_r);
      bo_w2_r <= SW'(bo_w_r) * SW'(bo_w_r);
      bo_l2_r <= SW'(bo_l_r) * SW'(bo_l_r);
      ot_p_r  <= SW'(ot_u_r) * SW'(pid_pkg::OUTER_TAPER_LEN);
      ot_q_r  <= SW'(ot_w_r) * SW'(pid_pkg::OUTER_TAPER_WID);
      tp_u2_r <= SW'(tp_u_r) * SW'(tp_u_r);
      tp_w2_r <= SW'(tp_w_r) * SW'(tp_w_r);
      tp_l2_r <= SW'(tp_l_r) * SW'(tp_l_r);
      bm_u2_r <= SW'(bm_u_r) * SW'(bm_u_r);
      bm_w2_r <= SW'(bm_w_r) * SW'(bm_w_r);
      bm_l2_r <= SW'(bm_l_r) * SW'(bm_l_r);
    end
  end

  // final compares into the output register
  logic pc_out, bo_out, ot_out, tp_out, bm_out, inside_nxt;
  assign pc_out = fm_r.pc_in && (fm_r.pc_short ||
                  ((SW+1)'(pc_u2_r) + (SW+1)'(pc_w2_r) <= (SW+1)'(pc_l2_r)));
  assign bo_out = fm_r.bo_in && (fm_r.bo_short ||
                  ((SW+1)'(bo_u2_r) + (SW+1)'(bo_w2_r) <= (SW+1)'(bo_l2_r)));
  assign ot_out = fm_r.ot_in && (ot_p_r <= ot_q_r);
  assign tp_out = fm_r.tp_in &&
                  ((SW+1)'(tp_u2_r) + (SW+1)'(tp_w2_r) >= (SW+1)'(tp_l2_r));
  assign bm_out = fm_r.bm_in &&
                  ((SW+1)'(bm_u2_r) + (SW+1)'(bm_w2_r) >= (SW+1)'(bm_l2_r));
  assign inside_nxt = !(fm_r.bad || pc_out || bo_out || ot_out || fm_r.bt_out ||
                        tp_out || bm_out);

  always_ff @(posedge clk) begin
    if (en[NS]) out_res_r <= inside_nxt;
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.inside_res = out_res_r;

  // input stalls only when every stage and the output register hold a beat
  `AST_IMP(a_full_stall, clk, rst_n, !in_bus.ready, out_v_r && !out_bus.ready && (&v_r))
  // a finished beat lands in an empty output register
  `AST_NXT(a_drain, clk, rst_n, v_r[NS-1] && !out_v_r, out_v_r)
  // a stalled result keeps its value
  `AST_NXT(a_hold, clk, rst_n, out_v_r && !out_bus.ready, out_v_r && $stable(out_res_r))
endmodule
`default_nettype wire
